>>> hw/rtl/rmd_pkg.sv
package rmd_pkg;

  localparam int WORD_W = 60;
  localparam int SLOT_COUNT = 4;
  localparam int SURV_COUNT = 3;
  localparam int SLOT_IDX_W = 2;
  localparam int LEVEL_W = 3;
  localparam int CFG_IDX_W = 3;
  localparam int DEF_PRIME_COUNT = 4;

  typedef logic [WORD_W-1:0] word_t;
  typedef logic [SLOT_COUNT-1:0][WORD_W-1:0] slot_vec_t;
  typedef logic [SURV_COUNT-1:0][WORD_W-1:0] surv_vec_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PRIME_ZERO    = 3'd0,
    REG_PRIME_ONE     = 3'd1,
    REG_PRIME_TWO     = 3'd2,
    REG_PRIME_THREE   = 3'd3,
    REG_ACTIVE_LEVEL  = 3'd4,
    REG_DROP_INV_ZERO = 3'd5,
    REG_DROP_INV_ONE  = 3'd6,
    REG_DROP_INV_TWO  = 3'd7
  } cfg_reg_t;

  // state carried beside the second reduction
  typedef struct packed {
    logic      neg;
    surv_vec_t res;
    surv_vec_t inv;
  } side_t;

  // one restoring step: shift in one dividend bit, subtract q if it fits
  function automatic word_t red_step(word_t rem, logic bitv, word_t q);
    logic [WORD_W:0] t;
    t = {rem, bitv};
    if (t >= {1'b0, q}) begin
      t = t - {1'b0, q};
    end
    return t[WORD_W-1:0];
  endfunction

  // a, b below q
  function automatic word_t add_mod(word_t a, word_t b, word_t q);
    logic [WORD_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= {1'b0, q}) begin
      s = s - {1'b0, q};
    end
    return s[WORD_W-1:0];
  endfunction

  function automatic word_t sub_mod(word_t a, word_t b, word_t q);
    word_t d;
    d = a - b;
    if (a < b) begin
      d = d + q;
    end
    return d;
  endfunction

endpackage

>>> hw/rtl/rmd_mod_reduce.sv
module rmd_mod_reduce
  import rmd_pkg::*;
#(
  parameter int LANES = SLOT_COUNT
) (
  input  logic                         clk,
  input  logic                         en,
  input  logic [LANES-1:0][WORD_W-1:0] x,
  input  logic [LANES-1:0][WORD_W-1:0] q,
  output logic [LANES-1:0][WORD_W-1:0] rem
);

  // one dividend bit per stage, msb first
  word_t rem_q [WORD_W][LANES];
  word_t x_q   [WORD_W-1][LANES];

  genvar s, l;
  for (s = 0; s < WORD_W; s++) begin : g_step
    for (l = 0; l < LANES; l++) begin : g_lane
      word_t rem_in;
      word_t x_in;
      if (s == 0) begin : g_first
        assign rem_in = '0;
        assign x_in   = x[l];
      end else begin : g_next
        assign rem_in = rem_q[s-1][l];
        assign x_in   = x_q[s-1][l];
      end
      always_ff @(posedge clk) begin
        if (en) begin
          rem_q[s][l] <= red_step(rem_in, x_in[WORD_W-1], q[l]);
        end
      end
      if (s < WORD_W-1) begin : g_shift
        always_ff @(posedge clk) begin
          if (en) begin
            x_q[s][l] <= {x_in[WORD_W-2:0], 1'b0};
          end
        end
      end
    end
  end

  for (l = 0; l < LANES; l++) begin : g_out
    assign rem[l] = rem_q[WORD_W-1][l];
  end

endmodule

>>> hw/rtl/rns_modulus_drop_core.sv
// throughput: one word per cycle while the output is not stalled; every stage takes a new word each enabled cycle
// depth is set by two 60-step restoring reductions and a 120-step modular multiply
// a stalled output freezes the whole pipeline, nothing is lost or repeated
// reset clears all valid bits and loads primes 2, level 4, inverses 0
module rns_modulus_drop_core
  import rmd_pkg::*;
#(
  parameter int PRIME_COUNT = DEF_PRIME_COUNT
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [WORD_W-1:0]    residue_in_zero,
  input  logic [WORD_W-1:0]    residue_in_one,
  input  logic [WORD_W-1:0]    residue_in_two,
  input  logic [WORD_W-1:0]    residue_in_three,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [WORD_W-1:0]    residue_out_zero,
  output logic [WORD_W-1:0]    residue_out_one,
  output logic [WORD_W-1:0]    residue_out_two,
  output logic [WORD_W-1:0]    residue_out_three,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [WORD_W-1:0]    cfg_data
);

  // stage map: reduce (W), center (1), reduce (W), negate (1), subtract (1),
  // multiply (2W half steps), output register (1)
  localparam int TOTAL = 4 * WORD_W + 4;
  localparam int MUL_STEPS = 2 * WORD_W;
  localparam logic [LEVEL_W-1:0] LEVEL_CAP = LEVEL_W'(PRIME_COUNT);

  // configuration registers
  slot_vec_t            prime;
  surv_vec_t            inv_cfg;
  logic [LEVEL_W-1:0]   active_level;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      prime        <= {SLOT_COUNT{WORD_W'(2)}};
      inv_cfg      <= '0;
      active_level <= LEVEL_W'(4);
    end else if (cfg_valid) begin
      case (cfg_reg_t'(cfg_index))
        REG_PRIME_ZERO:    prime[0] <= cfg_data;
        REG_PRIME_ONE:     prime[1] <= cfg_data;
        REG_PRIME_TWO:     prime[2] <= cfg_data;
        REG_PRIME_THREE:   prime[3] <= cfg_data;
        REG_ACTIVE_LEVEL:  active_level <= cfg_data[LEVEL_W-1:0];
        REG_DROP_INV_ZERO: inv_cfg[0] <= cfg_data;
        REG_DROP_INV_ONE:  inv_cfg[1] <= cfg_data;
        REG_DROP_INV_TWO:  inv_cfg[2] <= cfg_data;
        default: ;
      endcase
    end
  end

  // level handling; the user must keep config stable while words are in flight, the block does not enforce it
  logic [LEVEL_W-1:0]    lvl_eff;
  logic                  has_drop;
  logic [SLOT_IDX_W-1:0] drop;

  assign lvl_eff  = (active_level > LEVEL_CAP) ? LEVEL_CAP : active_level;
  assign has_drop = (lvl_eff >= LEVEL_W'(2));
  assign drop     = SLOT_IDX_W'(lvl_eff - LEVEL_W'(1));

  // valid bits and global stall
  logic [TOTAL-1:0] vld;
  logic             en;

  assign en        = !out_valid || out_ready;
  assign in_ready  = en;
  assign out_valid = vld[TOTAL-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[TOTAL-2:0], in_valid};
    end
  end

  // raw input residues ride along for passthrough slots
  slot_vec_t raw_in;
  slot_vec_t raw_q [TOTAL-1];

  assign raw_in = {residue_in_three, residue_in_two, residue_in_one, residue_in_zero};

  genvar k;
  for (k = 0; k < TOTAL-1; k++) begin : g_raw
    always_ff @(posedge clk) begin
      if (en) begin
        raw_q[k] <= (k == 0) ? raw_in : raw_q[(k == 0) ? 0 : k-1];
      end
    end
  end

  // first reduction: residues mod own prime, inverses mod their prime
  logic [SLOT_COUNT+SURV_COUNT-1:0][WORD_W-1:0] red1_x, red1_q, red1_rem;

  assign red1_x = {inv_cfg, raw_in};
  assign red1_q = {prime[SURV_COUNT-1:0], prime};

  rmd_mod_reduce #(
    .LANES(SLOT_COUNT + SURV_COUNT)
  ) u_red_in (
    .clk(clk),
    .en (en),
    .x  (red1_x),
    .q  (red1_q),
    .rem(red1_rem)
  );

  // center the dropped residue into sign and magnitude
  slot_vec_t red_res;
  word_t     r_drop;
  word_t     q_drop;
  logic      c_neg;
  word_t     c_mag;
  surv_vec_t c_res;
  surv_vec_t c_inv;

  assign red_res = red1_rem[SLOT_COUNT-1:0];
  assign r_drop  = red_res[drop];
  assign q_drop  = prime[drop];

  always_ff @(posedge clk) begin
    if (en) begin
      if (q_drop == '0) begin
        c_neg <= 1'b0;
        c_mag <= '0;
      end else if (r_drop > (q_drop >> 1)) begin
        c_neg <= 1'b1;
        c_mag <= q_drop - r_drop;
      end else begin
        c_neg <= 1'b0;
        c_mag <= r_drop;
      end
      c_res <= red_res[SURV_COUNT-1:0];
      c_inv <= red1_rem[SLOT_COUNT+SURV_COUNT-1:SLOT_COUNT];
    end
  end

  // second reduction: magnitude mod each surviving prime
  surv_vec_t mag_x;
  surv_vec_t mag_rem;
  side_t     side_q [WORD_W];

  assign mag_x = {SURV_COUNT{c_mag}};

  rmd_mod_reduce #(
    .LANES(SURV_COUNT)
  ) u_red_mag (
    .clk(clk),
    .en (en),
    .x  (mag_x),
    .q  (prime[SURV_COUNT-1:0]),
    .rem(mag_rem)
  );

  for (k = 0; k < WORD_W; k++) begin : g_side
    always_ff @(posedge clk) begin
      if (en) begin
        if (k == 0) begin
          side_q[k] <= '{neg: c_neg, res: c_res, inv: c_inv};
        end else begin
          side_q[k] <= side_q[(k == 0) ? 0 : k-1];
        end
      end
    end
  end

  // signed shift value, then the difference mod q
  surv_vec_t d1_s, d1_res, d1_inv;
  surv_vec_t d2_a, d2_b;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < SURV_COUNT; i++) begin
        if (side_q[WORD_W-1].neg && (mag_rem[i] != '0)) begin
          d1_s[i] <= prime[i] - mag_rem[i];
        end else begin
          d1_s[i] <= mag_rem[i];
        end
      end
      d1_res <= side_q[WORD_W-1].res;
      d1_inv <= side_q[WORD_W-1].inv;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < SURV_COUNT; i++) begin
        d2_a[i] <= sub_mod(d1_res[i], d1_s[i], prime[i]);
      end
      d2_b <= d1_inv;
    end
  end

  // modular multiply, msb first: even half steps double, odd ones add a when the current b bit is set
  surv_vec_t mul_acc [MUL_STEPS];
  surv_vec_t mul_a   [MUL_STEPS-1];
  surv_vec_t mul_b   [MUL_STEPS-1];

  genvar j;
  for (j = 0; j < MUL_STEPS; j++) begin : g_mul
    surv_vec_t acc_in, a_in, b_in;
    if (j == 0) begin : g_first
      assign acc_in = '0;
      assign a_in   = d2_a;
      assign b_in   = d2_b;
    end else begin : g_next
      assign acc_in = mul_acc[j-1];
      assign a_in   = mul_a[j-1];
      assign b_in   = mul_b[j-1];
    end
    always_ff @(posedge clk) begin
      if (en) begin
        for (int i = 0; i < SURV_COUNT; i++) begin
          if ((j % 2) == 0) begin
            mul_acc[j][i] <= add_mod(acc_in[i], acc_in[i], prime[i]);
          end else if (b_in[i][WORD_W-1]) begin
            mul_acc[j][i] <= add_mod(acc_in[i], a_in[i], prime[i]);
          end else begin
            mul_acc[j][i] <= acc_in[i];
          end
        end
      end
    end
    if (j < MUL_STEPS-1) begin : g_pass
      always_ff @(posedge clk) begin
        if (en) begin
          mul_a[j] <= a_in;
          for (int i = 0; i < SURV_COUNT; i++) begin
            if ((j % 2) == 1) begin
              mul_b[j][i] <= {b_in[i][WORD_W-2:0], 1'b0};
            end else begin
              mul_b[j][i] <= b_in[i];
            end
          end
        end
      end
    end
  end

  // pick per slot: rescaled (zero if its prime is zero), zero for the dropped one, or passthrough
  slot_vec_t out_next;

  always_comb begin
    for (int i = 0; i < SLOT_COUNT; i++) begin
      if (!has_drop || (SLOT_IDX_W'(i) > drop)) begin
        out_next[i] = raw_q[TOTAL-2][i];
      end else if (SLOT_IDX_W'(i) == drop) begin
        out_next[i] = '0;
      end else if (prime[i] == '0) begin
        out_next[i] = '0;
      end else begin
        out_next[i] = mul_acc[MUL_STEPS-1][(i < SURV_COUNT) ? i : 0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      residue_out_zero  <= out_next[0];
      residue_out_one   <= out_next[1];
      residue_out_two   <= out_next[2];
      residue_out_three <= out_next[3];
    end
  end

  // dropped top slot always reads zero
  a_drop_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && has_drop && (drop == SLOT_IDX_W'(3)) |-> residue_out_three == '0)
    else $error("dropped slot three not zero");

  // rescaled slot zero is fully reduced
  a_slot0_reduced: assert property (@(posedge clk) disable iff (rst)
    out_valid && has_drop && (drop != '0) && (prime[0] != '0)
      |-> residue_out_zero < prime[0])
    else $error("slot zero result not below its prime");

  // a stalled output freezes every valid bit
  a_stall_freeze: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(vld))
    else $error("pipeline moved during stall");

  // nothing comes out right after reset
  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("output valid right after reset");

endmodule
